@@ sv/gds_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gds_pkg
// Types, codes and calendar helpers shared by the date stepper modules.
// ----------------------------------------------------------------------------
package gds_pkg;

    // field widths
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 23;
    localparam int CODE_W  = 2;

    // calendar limits
    localparam logic [YEAR_W-1:0]  YEAR_MIN  = YEAR_W'(1900);
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = YEAR_W'(9999);
    localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   DAY_FIRST = DAY_W'(1);
    localparam logic [DAY_W-1:0]   DAY_DEC31 = DAY_W'(31);

    // year / 100 by reciprocal: (y * 5243) >> 19 is exact for 14-bit years
    localparam int                 QUOT_MUL_W = 13;
    localparam logic [QUOT_MUL_W-1:0] QUOT_MUL = QUOT_MUL_W'(5243);
    localparam int                 QUOT_SHIFT = 19;
    localparam int                 QUOT_W     = 8;
    localparam int                 PROD_W     = YEAR_W + QUOT_MUL_W;

    // operation modes
    typedef enum logic [CODE_W-1:0] {
        MODE_LOAD    = 2'd0,
        MODE_ADD     = 2'd1,
        MODE_COMPARE = 2'd2,
        MODE_NONE    = 2'd3
    } t_mode;

    // result status codes
    localparam logic [CODE_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [CODE_W-1:0] STATUS_INVALID = 2'd1;
    localparam logic [CODE_W-1:0] STATUS_UPPER   = 2'd2;
    localparam logic [CODE_W-1:0] STATUS_LOWER   = 2'd3;

    // compare results
    localparam logic [CODE_W-1:0] ORDER_EARLIER = 2'd0;
    localparam logic [CODE_W-1:0] ORDER_EQUAL   = 2'd1;
    localparam logic [CODE_W-1:0] ORDER_LATER   = 2'd2;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_EXEC,
        ST_WALK,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic              capture;
        logic              commit;
        logic              step;
        logic              set_status;
        logic [CODE_W-1:0] status_code;
        logic              set_order;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_mode mode;
        logic  load_ok;
        logic  cnt_zero;
        logic  blocked_hi;
        logic  blocked_lo;
    } t_dp_stat;

    // days in a month; out-of-range months read as 31
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd4, 4'd6, 4'd9, 4'd11: len = DAY_W'(30);
            4'd2:                    len = leap ? DAY_W'(29) : DAY_W'(28);
            default:                 len = DAY_W'(31);
        endcase
        return len;
    endfunction

endpackage

@@ sv/gds_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gds_ctrl
// Sequencer for load, day walk and compare; drives the datapath commands.
// ----------------------------------------------------------------------------
module gds_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  gds_pkg::t_dp_stat i_stat,
    output gds_pkg::t_dp_cmd  o_cmd,
    output logic              busy,
    output logic              o_done
);
    import gds_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (i_stat.mode == MODE_ADD) begin
                    n_state = ST_WALK;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_WALK: begin
                if (i_stat.cnt_zero || i_stat.blocked_hi || i_stat.blocked_lo) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.capture = start;
            end
            ST_PREP: begin
            end
            ST_EXEC: begin
                unique case (i_stat.mode)
                    MODE_LOAD: begin
                        if (i_stat.load_ok) begin
                            o_cmd.commit = 1'b1;
                        end else begin
                            o_cmd.set_status  = 1'b1;
                            o_cmd.status_code = STATUS_INVALID;
                        end
                    end
                    MODE_COMPARE: begin
                        o_cmd.set_order = 1'b1;
                    end
                    MODE_ADD, MODE_NONE: begin
                    end
                endcase
            end
            ST_WALK: begin
                priority if (i_stat.cnt_zero) begin
                    o_cmd.commit = 1'b1;
                end else if (i_stat.blocked_hi) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = STATUS_UPPER;
                end else if (i_stat.blocked_lo) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = STATUS_LOWER;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_DONE: begin
            end
        endcase
    end

    assign busy   = (r_state != ST_IDLE);
    assign o_done = (r_state == ST_DONE);

endmodule

@@ sv/gds_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gds_datapath
// Stored date, working date, leap-year unit, one-day stepper and compare.
// ----------------------------------------------------------------------------
module gds_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gds_pkg::t_dp_cmd             i_cmd,
    input  logic [1:0]                   i_mode,
    input  logic [gds_pkg::YEAR_W-1:0]   i_in_year,
    input  logic [gds_pkg::MONTH_W-1:0]  i_in_month,
    input  logic [gds_pkg::DAY_W-1:0]    i_in_day,
    input  logic [gds_pkg::COUNT_W-1:0]  i_day_count,
    output gds_pkg::t_dp_stat            o_stat,
    output logic [gds_pkg::YEAR_W-1:0]   o_out_year,
    output logic [gds_pkg::MONTH_W-1:0]  o_out_month,
    output logic [gds_pkg::DAY_W-1:0]    o_out_day,
    output logic [gds_pkg::CODE_W-1:0]   o_status,
    output logic [gds_pkg::CODE_W-1:0]   o_order
);
    import gds_pkg::*;

    // stored date
    logic [YEAR_W-1:0]  r_cur_y;
    logic [MONTH_W-1:0] r_cur_m;
    logic [DAY_W-1:0]   r_cur_d;
    // working date
    logic [YEAR_W-1:0]  r_wy;
    logic [MONTH_W-1:0] r_wm;
    logic [DAY_W-1:0]   r_wd;
    logic [YEAR_W-1:0]  n_wy;
    logic [MONTH_W-1:0] n_wm;
    logic [DAY_W-1:0]   n_wd;
    // walk control
    logic [COUNT_W-1:0] r_cnt;
    logic               r_back;
    t_mode              r_mode;
    logic [CODE_W-1:0]  r_status;
    logic [CODE_W-1:0]  r_order;
    // leap unit
    logic [QUOT_W-1:0]  r_q;
    logic [PROD_W-1:0]  quot_prod;
    logic [YEAR_W:0]    cent_mul;
    logic               century;
    logic               leap;
    logic [DAY_W-1:0]   cur_len;
    logic [DAY_W-1:0]   prev_len;
    logic [MONTH_W-1:0] prev_m;
    logic [COUNT_W-1:0] count_mag;
    logic [CODE_W-1:0]  cmp_order;

    // year / 100, registered; the working year is settled before the quotient is used
    assign quot_prod = PROD_W'(r_wy) * PROD_W'(QUOT_MUL);
    always_ff @(posedge i_clk) begin
        r_q <= quot_prod[QUOT_SHIFT +: QUOT_W];
    end

    // leap rule from the registered quotient; a stale quotient right after a
    // year change is harmless, the walk then sits on January 1 or December 31
    assign cent_mul = {1'b0, r_q, 6'b0} + {2'b0, r_q, 5'b0} + {5'b0, r_q, 2'b0};
    assign century  = (cent_mul == {1'b0, r_wy});
    assign leap     = (r_wy[1:0] == 2'b00) && (!century || (r_q[1:0] == 2'b00));
    assign cur_len  = month_len(r_wm, leap);
    assign prev_m   = r_wm - MONTH_W'(1);
    assign prev_len = month_len(prev_m, leap);

    // magnitude of the signed count
    assign count_mag = i_day_count[COUNT_W-1] ? (~i_day_count + COUNT_W'(1)) : i_day_count;

    // one day forward or backward
    always_comb begin
        n_wy = r_wy;
        n_wm = r_wm;
        n_wd = r_wd;
        if (!r_back) begin
            if (r_wd == cur_len) begin
                n_wd = DAY_FIRST;
                if (r_wm == MONTH_DEC) begin
                    n_wm = MONTH_JAN;
                    n_wy = r_wy + YEAR_W'(1);
                end else begin
                    n_wm = r_wm + MONTH_W'(1);
                end
            end else begin
                n_wd = r_wd + DAY_W'(1);
            end
        end else begin
            if (r_wd == DAY_FIRST) begin
                if (r_wm == MONTH_JAN) begin
                    n_wy = r_wy - YEAR_W'(1);
                    n_wm = MONTH_DEC;
                    n_wd = DAY_DEC31;
                end else begin
                    n_wm = prev_m;
                    n_wd = prev_len;
                end
            end else begin
                n_wd = r_wd - DAY_W'(1);
            end
        end
    end

    // stored date against the given one, field by field
    always_comb begin
        priority if (r_cur_y != r_wy) begin
            cmp_order = (r_cur_y < r_wy) ? ORDER_EARLIER : ORDER_LATER;
        end else if (r_cur_m != r_wm) begin
            cmp_order = (r_cur_m < r_wm) ? ORDER_EARLIER : ORDER_LATER;
        end else if (r_cur_d != r_wd) begin
            cmp_order = (r_cur_d < r_wd) ? ORDER_EARLIER : ORDER_LATER;
        end else begin
            cmp_order = ORDER_EQUAL;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= t_mode'(i_mode);
            r_cnt  <= count_mag;
            r_back <= i_day_count[COUNT_W-1];
            if (t_mode'(i_mode) == MODE_ADD) begin
                r_wy <= r_cur_y;
                r_wm <= r_cur_m;
                r_wd <= r_cur_d;
            end else begin
                r_wy <= i_in_year;
                r_wm <= i_in_month;
                r_wd <= i_in_day;
            end
        end else if (i_cmd.step) begin
            r_wy  <= n_wy;
            r_wm  <= n_wm;
            r_wd  <= n_wd;
            r_cnt <= r_cnt - COUNT_W'(1);
        end
    end

    // result codes
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_status <= STATUS_OK;
            r_order  <= ORDER_EARLIER;
        end else begin
            if (i_cmd.set_status) begin
                r_status <= i_cmd.status_code;
            end
            if (i_cmd.set_order) begin
                r_order <= cmp_order;
            end
        end
    end

    // stored date
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_y <= YEAR_MIN;
            r_cur_m <= MONTH_JAN;
            r_cur_d <= DAY_FIRST;
        end else if (i_cmd.commit) begin
            r_cur_y <= r_wy;
            r_cur_m <= r_wm;
            r_cur_d <= r_wd;
        end
    end

    // status toward the controller
    assign o_stat.mode       = r_mode;
    assign o_stat.load_ok    = (r_wy >= YEAR_MIN) && (r_wy <= YEAR_MAX)
                             && (r_wm >= MONTH_JAN) && (r_wm <= MONTH_DEC)
                             && (r_wd >= DAY_FIRST) && (r_wd <= cur_len);
    assign o_stat.cnt_zero   = (r_cnt == '0);
    assign o_stat.blocked_hi = !r_back && (r_wy == YEAR_MAX) && (r_wm == MONTH_DEC)
                             && (r_wd == DAY_DEC31);
    assign o_stat.blocked_lo = r_back && (r_wy == YEAR_MIN) && (r_wm == MONTH_JAN)
                             && (r_wd == DAY_FIRST);

    assign o_out_year  = r_cur_y;
    assign o_out_month = r_cur_m;
    assign o_out_day   = r_cur_d;
    assign o_status    = r_status;
    assign o_order     = r_order;

endmodule

@@ sv/gregorian_date_stepper.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_stepper
// Holds one Gregorian date and loads, shifts or compares it on command.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy stays high until
// the result word has been shown. The result appears on the o_out_* ports with
// o_done high for exactly one cycle and must be captured then, since the block
// cannot be held off. Load, compare and the unused mode go from the prep state
// through execute to done. Adding days puts a walk state before done, which
// moves the date one day per clock through the stepper until the count is used
// up; a walk that would leave 1900-01-01..9999-12-31 stops when it reaches the
// limit, and then leaves the date as it was. After reset the stored date is
// 1900-01-01.
module gregorian_date_stepper (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_mode,
    input  logic [gds_pkg::YEAR_W-1:0]   i_in_year,
    input  logic [gds_pkg::MONTH_W-1:0]  i_in_month,
    input  logic [gds_pkg::DAY_W-1:0]    i_in_day,
    input  logic [gds_pkg::COUNT_W-1:0]  i_day_count,
    output logic                         o_done,
    output logic [gds_pkg::YEAR_W-1:0]   o_out_year,
    output logic [gds_pkg::MONTH_W-1:0]  o_out_month,
    output logic [gds_pkg::DAY_W-1:0]    o_out_day,
    output logic [gds_pkg::CODE_W-1:0]   o_status,
    output logic [gds_pkg::CODE_W-1:0]   o_order
);
    import gds_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer
    gds_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    // date registers and arithmetic
    gds_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_mode      (i_mode),
        .i_in_year   (i_in_year),
        .i_in_month  (i_in_month),
        .i_in_day    (i_in_day),
        .i_day_count (i_day_count),
        .o_stat      (dp_stat),
        .o_out_year  (o_out_year),
        .o_out_month (o_out_month),
        .o_out_day   (o_out_day),
        .o_status    (o_status),
        .o_order     (o_order)
    );

    // a result word is only shown inside a command
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe outside a command");

    // the stored date moves only into a result word
    a_date_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((o_out_year != $past(o_out_year)) || (o_out_month != $past(o_out_month))
         || (o_out_day != $past(o_out_day))) |-> o_done)
        else $error("stored date changed outside a result");

    // at each result the stored year and month lie in range and the day is at least 1
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_out_month >= MONTH_JAN) && (o_out_month <= MONTH_DEC)
                   && (o_out_day >= DAY_FIRST) && (o_out_year >= YEAR_MIN)
                   && (o_out_year <= YEAR_MAX))
        else $error("stored date out of range");

    // a compare result of equal or later never carries an error status
    a_order_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_order != ORDER_EARLIER)) |-> (o_status == STATUS_OK))
        else $error("order set together with an error status");

endmodule
